// ===== hdl/bioc_pkg.sv =====
// ----------------------------------------------------------------------------
// bioc_pkg
// Shared types and constants of the binned interval overlap counter.
// ----------------------------------------------------------------------------
package bioc_pkg;

  localparam int unsigned COORD_W = 31;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned OFS_W   = 12;
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned SRC_W   = 8;
  localparam int unsigned CHR_W   = 5;
  localparam int unsigned TILE_W  = 10;
  localparam int unsigned REQ_W   = 3;
  // base plus record index, before the wrap onto the record store
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned DIR_W   = OFS_W + IDX_W;
  localparam int unsigned REC_W   = 2 * COORD_W + SRC_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET_TILES = 3'd0,
    REQ_LOAD_TILE = 3'd1,
    REQ_LOAD_REC  = 3'd2,
    REQ_QUERY     = 3'd3,
    REQ_COUNTER   = 3'd4
  } req_e;

  typedef struct packed {
    logic [COORD_W-1:0] quot;
    logic [COORD_W-1:0] rem;
  } div_res_t;

endpackage

// ===== hdl/bioc_ram.sv =====
// ----------------------------------------------------------------------------
// bioc_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bioc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bioc_div.sv =====
// ----------------------------------------------------------------------------
// bioc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bioc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bioc_pkg::COORD_W-1:0] dividend_i,
  input  logic [bioc_pkg::COORD_W-1:0] divisor_i,
  output logic                        done_o,
  output bioc_pkg::div_res_t          res_o
);
  import bioc_pkg::*;

  localparam int unsigned CW = $clog2(COORD_W + 1);

  logic [COORD_W-1:0] quot_q, rem_q, dvs_q;
  logic [CW-1:0]      cnt_q;
  logic               done_q;
  logic [COORD_W:0]   shifted, diff;
  logic               take;

  assign shifted = {rem_q, quot_q[COORD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign take    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(COORD_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      quot_q <= {quot_q[COORD_W-2:0], take};
      rem_q  <= take ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
    end
  end

  assign done_o   = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

// ===== hdl/binned_interval_overlap_counter_core.sv =====
// ----------------------------------------------------------------------------
// binned_interval_overlap_counter_core
// Tiled interval index with per-source overlap counters.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (in_valid_i / in_stall_o), one beat per
// request; every request returns exactly one beat on the output channel
// (out_valid_o / out_stall_i). A beat is taken when valid is high and stall low.
// Loads of tile counts, tile entries and records finish in the accept cycle;
// a counter read answers from ST_CRD, after the registered counter RAM read.
// A query runs up to two serial divisions (start, then end minus one), then
// per visited tile a directory read and record fetches; each record fetch
// wraps its address onto the record store and then reads it, and a counted
// record adds a counter write. How long a query runs is set by the record
// fetches of search and scan.
// The block takes a new request only when the output slot is empty or is being
// emptied, so a stalled receiver holds off new requests.
// Reset clears the tile counts and all counters (through per-counter valid
// bits); directory and record stores stay undefined until loaded. The user
// must write tile_width via cfg_we_i / cfg_wdata_i only while idle (unchecked).
// ----------------------------------------------------------------------------
module binned_interval_overlap_counter_core #(
  parameter int unsigned NUM_SEQS      = 32,
  parameter int unsigned TILES_PER_SEQ = 1024,
  parameter int unsigned RECORD_DEPTH  = 4096,
  parameter int unsigned NUM_SOURCES   = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bioc_pkg::COORD_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bioc_pkg::REQ_W-1:0]   req_type_i,
  input  logic [bioc_pkg::CHR_W-1:0]   chrom_i,
  input  logic [bioc_pkg::TILE_W-1:0]  tile_i,
  input  logic [bioc_pkg::OFS_W-1:0]   offset_i,
  input  logic [bioc_pkg::IDX_W-1:0]   count_i,
  input  logic [bioc_pkg::COORD_W-1:0] coord_start_i,
  input  logic [bioc_pkg::COORD_W-1:0] coord_end_i,
  input  logic [bioc_pkg::SRC_W-1:0]   file_index_i,
  input  logic                         clear_flag_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bioc_pkg::CNT_W-1:0]   hit_value_o,
  output logic                         status_o
);
  import bioc_pkg::*;

  localparam int unsigned DIR_DEPTH = NUM_SEQS * TILES_PER_SEQ;
  localparam int unsigned DIR_AW = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
  localparam int unsigned REC_AW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int unsigned SRC_AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int unsigned SEQ_AW = (NUM_SEQS > 1) ? $clog2(NUM_SEQS) : 1;
  localparam int unsigned NT_W   = $clog2(TILES_PER_SEQ + 1);
  localparam int unsigned RK_W   = $clog2(SUM_W);
  localparam int unsigned LOW_W  = COORD_W + 2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CRD, ST_DIV1, ST_DIV2, ST_DIR, ST_DIRW, ST_FSUM, ST_FRED,
    ST_FRD, ST_FDAT, ST_BLOOP, ST_SLOOP, ST_CWAIT, ST_NEXT
  } state_e;

  typedef enum logic [2:0] {
    RET_CHK0, RET_SKIP, RET_MID, RET_HI, RET_SCAN
  } ret_e;

  state_e state_q;
  ret_e   ret_q;

  logic [COORD_W-1:0] tile_width_q, tw;
  logic [NT_W-1:0]    seq_tiles_q [NUM_SEQS];
  logic [NUM_SOURCES-1:0] cnt_vld_q;

  logic               out_valid_q, status_q;
  logic [CNT_W-1:0]   hit_value_q;

  logic [CHR_W-1:0]   chrom_q;
  logic [COORD_W-1:0] qs_q, qe_q;
  logic [NT_W-1:0]    ntiles_q;
  logic [NT_W-1:0]    j_q, n1_q, n2_q;
  logic [LOW_W-1:0]   lower_q;
  logic [OFS_W-1:0]   base_q;
  logic [IDX_W-1:0]   n_q, idx_q, first_q, lo_q, hi_q, i_q;
  logic [SUM_W-1:0]   sum_q;
  logic [RK_W-1:0]    red_k_q;
  logic [SRC_W-1:0]   csrc_q;

  logic accept;
  logic div_start, div_done;
  logic [COORD_W-1:0] div_dividend;
  div_res_t div_res;

  logic              dir_we, dir_re;
  logic [DIR_AW-1:0] dir_waddr, dir_raddr;
  logic [DIR_W-1:0]  dir_rdata;
  logic              rec_we, rec_re;
  logic [REC_W-1:0]  rec_rdata;
  logic              cnt_we, cnt_re;
  logic [SRC_AW-1:0] cnt_raddr;
  logic [CNT_W-1:0]  cnt_rdata, cnt_old, cnt_new;

  logic [COORD_W-1:0] r_start, r_end;
  logic [SRC_W-1:0]   r_src;
  logic               r_hit;
  logic [33:0]        red_cmp;
  logic [IDX_W:0]     lo_p1, lohi;

  assign tw     = (tile_width_q == '0) ? COORD_W'(1) : tile_width_q;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);

  assign r_start = rec_rdata[REC_W-1 -: COORD_W];
  assign r_end   = rec_rdata[SRC_W +: COORD_W];
  assign r_src   = rec_rdata[SRC_W-1:0];
  assign r_hit   = (r_end > qs_q) && (32'(r_src) < NUM_SOURCES);

  assign red_cmp = 34'(RECORD_DEPTH) << red_k_q;
  assign lo_p1   = {1'b0, lo_q} + 1'b1;
  assign lohi    = {1'b0, lo_q} + {1'b0, hi_q};

  // divider: query start first, then query end minus one
  assign div_start = (accept && req_type_i == REQ_QUERY && 32'(chrom_i) < NUM_SEQS) ||
                     (state_q == ST_DIV1 && div_done && qe_q != '0 &&
                      div_res.quot < COORD_W'(ntiles_q));
  assign div_dividend = (state_q == ST_IDLE) ? coord_start_i : qe_q - 1'b1;

  bioc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (tw),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  assign dir_we    = accept && req_type_i == REQ_LOAD_TILE &&
                     32'(chrom_i) < NUM_SEQS && 32'(tile_i) < TILES_PER_SEQ;
  assign dir_waddr = DIR_AW'(32'(chrom_i) * TILES_PER_SEQ + 32'(tile_i));
  assign dir_re    = (state_q == ST_DIR);
  assign dir_raddr = DIR_AW'(32'(chrom_q) * TILES_PER_SEQ + 32'(j_q));

  bioc_ram #(.WIDTH(DIR_W), .DEPTH(DIR_DEPTH)) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i ({offset_i, count_i}),
    .re_i    (dir_re),
    .raddr_i (dir_raddr),
    .rdata_o (dir_rdata)
  );

  assign rec_we = accept && req_type_i == REQ_LOAD_REC && 32'(offset_i) < RECORD_DEPTH;
  assign rec_re = (state_q == ST_FRD);

  bioc_ram #(.WIDTH(REC_W), .DEPTH(RECORD_DEPTH)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (REC_AW'(offset_i)),
    .wdata_i ({coord_start_i, coord_end_i, file_index_i}),
    .re_i    (rec_re),
    .raddr_i (REC_AW'(sum_q)),
    .rdata_o (rec_rdata)
  );

  // counter read for a read request, or for a counted record
  assign cnt_re = (accept && req_type_i == REQ_COUNTER && !clear_flag_i &&
                   32'(file_index_i) < NUM_SOURCES) ||
                  (state_q == ST_FDAT && ret_q == RET_SCAN && r_hit);
  assign cnt_raddr = (state_q == ST_IDLE) ? SRC_AW'(file_index_i) : SRC_AW'(r_src);
  assign cnt_we  = (state_q == ST_CWAIT);
  assign cnt_old = cnt_vld_q[SRC_AW'(csrc_q)] ? cnt_rdata : '0;
  assign cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + 1'b1;

  bioc_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SOURCES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (SRC_AW'(csrc_q)),
    .wdata_i (cnt_new),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_width_q <= COORD_W'(16384);
    end else if (cfg_we_i) begin
      tile_width_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SEQS; s++) begin
        seq_tiles_q[s] <= '0;
      end
    end else if (accept && req_type_i == REQ_SET_TILES && 32'(chrom_i) < NUM_SEQS) begin
      seq_tiles_q[SEQ_AW'(chrom_i)] <= (32'(count_i) > TILES_PER_SEQ) ?
                                       NT_W'(TILES_PER_SEQ) : NT_W'(count_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (accept && req_type_i == REQ_COUNTER && clear_flag_i) begin
      cnt_vld_q <= '0;
    end else if (cnt_we) begin
      cnt_vld_q[SRC_AW'(csrc_q)] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= RET_CHK0;
      out_valid_q <= 1'b0;
      status_q    <= 1'b0;
      hit_value_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            chrom_q <= chrom_i;
            qs_q    <= coord_start_i;
            qe_q    <= coord_end_i;
            csrc_q  <= file_index_i;
            priority if (req_type_i == REQ_QUERY && 32'(chrom_i) < NUM_SEQS) begin
              ntiles_q <= seq_tiles_q[SEQ_AW'(chrom_i)];
              state_q  <= ST_DIV1;
            end else if (req_type_i == REQ_QUERY) begin
              out_valid_q <= 1'b1;
              status_q    <= 1'b1;
              hit_value_q <= '0;
            end else if (cnt_re) begin
              state_q <= ST_CRD;
            end else begin
              out_valid_q <= 1'b1;
              status_q    <= 1'b0;
              hit_value_q <= '0;
            end
          end
        end
        ST_CRD: begin
          out_valid_q <= 1'b1;
          status_q    <= 1'b0;
          hit_value_q <= cnt_vld_q[SRC_AW'(csrc_q)] ? cnt_rdata : '0;
          state_q     <= ST_IDLE;
        end
        ST_DIV1: begin
          if (div_done) begin
            if (div_res.quot >= COORD_W'(ntiles_q)) begin
              out_valid_q <= 1'b1;
              status_q    <= 1'b1;
              hit_value_q <= '0;
              state_q     <= ST_IDLE;
            end else begin
              n1_q    <= NT_W'(div_res.quot);
              j_q     <= NT_W'(div_res.quot);
              lower_q <= LOW_W'(qs_q) - LOW_W'(div_res.rem);
              if (qe_q == '0) begin
                n2_q    <= NT_W'(div_res.quot);
                state_q <= ST_DIR;
              end else begin
                state_q <= ST_DIV2;
              end
            end
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            n2_q <= (div_res.quot > COORD_W'(ntiles_q - 1'b1)) ?
                    ntiles_q - 1'b1 : NT_W'(div_res.quot);
            state_q <= ST_DIR;
          end
        end
        ST_DIR: begin
          state_q <= ST_DIRW;
        end
        ST_DIRW: begin
          base_q <= dir_rdata[DIR_W-1 -: OFS_W];
          n_q    <= dir_rdata[IDX_W-1:0];
          if (dir_rdata[IDX_W-1:0] == '0) begin
            state_q <= ST_NEXT;
          end else begin
            idx_q   <= '0;
            ret_q   <= RET_CHK0;
            state_q <= ST_FSUM;
          end
        end
        ST_FSUM: begin
          sum_q   <= SUM_W'(base_q) + SUM_W'(idx_q);
          red_k_q <= RK_W'(SUM_W - 1);
          state_q <= ST_FRED;
        end
        ST_FRED: begin
          // wrap onto the record store, one shifted subtract a cycle
          if ({20'b0, sum_q} >= red_cmp) begin
            sum_q <= sum_q - red_cmp[SUM_W-1:0];
          end
          if (red_k_q == '0) begin
            state_q <= ST_FRD;
          end else begin
            red_k_q <= red_k_q - 1'b1;
          end
        end
        ST_FRD: begin
          state_q <= ST_FDAT;
        end
        ST_FDAT: begin
          unique case (ret_q)
            RET_CHK0: begin
              first_q <= '0;
              lo_q    <= '0;
              hi_q    <= n_q - 1'b1;
              priority if (!(qe_q > r_start)) begin
                state_q <= ST_NEXT;
              end else if (j_q != n1_q) begin
                idx_q   <= '0;
                ret_q   <= RET_SKIP;
                state_q <= ST_FSUM;
              end else begin
                state_q <= ST_BLOOP;
              end
            end
            RET_SKIP: begin
              if (LOW_W'(r_start) < lower_q) begin
                first_q <= first_q + 1'b1;
                if (first_q + 1'b1 < n_q) begin
                  idx_q   <= first_q + 1'b1;
                  state_q <= ST_FSUM;
                end else begin
                  state_q <= ST_BLOOP;
                end
              end else begin
                state_q <= ST_BLOOP;
              end
            end
            RET_MID: begin
              if (r_start < qe_q) begin
                lo_q <= idx_q;
              end else begin
                hi_q <= idx_q;
              end
              state_q <= ST_BLOOP;
            end
            RET_HI: begin
              i_q     <= (r_start < qe_q) ? hi_q + 1'b1 : IDX_W'(lo_p1);
              state_q <= ST_SLOOP;
            end
            RET_SCAN: begin
              csrc_q  <= r_src;
              i_q     <= i_q - 1'b1;
              state_q <= r_hit ? ST_CWAIT : ST_SLOOP;
            end
            default: state_q <= ST_IDLE;
          endcase
        end
        ST_BLOOP: begin
          if (lo_p1 < {1'b0, hi_q}) begin
            idx_q <= lohi[IDX_W:1];
            ret_q <= RET_MID;
          end else begin
            idx_q <= hi_q;
            ret_q <= RET_HI;
          end
          state_q <= ST_FSUM;
        end
        ST_SLOOP: begin
          if (i_q > first_q) begin
            idx_q   <= i_q - 1'b1;
            ret_q   <= RET_SCAN;
            state_q <= ST_FSUM;
          end else begin
            state_q <= ST_NEXT;
          end
        end
        ST_CWAIT: begin
          state_q <= ST_SLOOP;
        end
        ST_NEXT: begin
          if (j_q < n2_q) begin
            j_q     <= j_q + 1'b1;
            lower_q <= lower_q + LOW_W'(tw);
            state_q <= ST_DIR;
          end else begin
            out_valid_q <= 1'b1;
            status_q    <= 1'b0;
            hit_value_q <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_value_o = hit_value_q;
  assign status_o    = status_q;

  // output slot stays empty while a request is in flight
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("result pending during busy request");

  a_div_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
    else $error("divider finished outside a division step");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (hit_value_o == '0))
    else $error("ignored query carries a counter value");

  a_cnt_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> $past(state_q == ST_FDAT && ret_q == RET_SCAN))
    else $error("counter write without a counted record");

endmodule
